FILE: hw/rtl/dlpg_pkg.sv
`timescale 1ns / 1ps

package dlpg_pkg;

    // command field codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture endpoints, set up the dividers
        logic step;     // one restoring division step on both axes
        logic advance;  // add increments and register the new pixel
        logic emit;     // register the start pixel
    } dlpg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_len; // endpoints on the input ports coincide
        logic active;   // pixels remain on the current line
    } dlpg_status_t;

endpackage

FILE: hw/rtl/dlpg_datapath.sv
`timescale 1ns / 1ps

module dlpg_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dlpg_pkg::dlpg_cmd_t          cmd,
    output dlpg_pkg::dlpg_status_t       status,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last_pixel
);

    localparam int STEP_BITS = COORD_BITS + 1;
    localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS  = FRAC_BITS + 2;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam int EXT_BITS  = POS_BITS - INC_BITS;
    localparam logic [POS_BITS-1:0] HALF = POS_BITS'(1) << (FRAC_BITS - 1);

    // lane 0 is x, lane 1 is y
    logic [COORD_BITS-1:0] p0 [2];
    logic [COORD_BITS-1:0] p1 [2];
    logic [COORD_BITS:0]   d    [2];
    logic [COORD_BITS:0]   dneg [2];
    logic [COORD_BITS-1:0] mag  [2];
    logic [COORD_BITS-1:0] span;

    logic [POS_BITS-1:0]   pos_reg  [2];
    logic [POS_BITS-1:0]   pos_next [2];
    logic [STEP_BITS-1:0]  rem_reg  [2];
    logic [Q_BITS-1:0]     q_reg    [2];
    logic                  neg_reg  [2];
    logic [COORD_BITS-1:0] span_reg;
    logic [STEP_BITS-1:0]  steps_reg;

    logic [STEP_BITS:0]    trial [2];
    logic                  ge    [2];
    logic [STEP_BITS-1:0]  rem   [2];
    logic [INC_BITS-1:0]   qmag  [2];
    logic [INC_BITS-1:0]   inc   [2];
    logic [POS_BITS-1:0]   rnd_adv [2];
    logic [POS_BITS-1:0]   rnd_cur [2];

    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic                  last_reg;

    assign p0[0] = start_x;
    assign p0[1] = start_y;
    assign p1[0] = end_x;
    assign p1[1] = end_y;

    // endpoint deltas and their magnitudes
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            d[i]    = {p1[i][COORD_BITS-1], p1[i]} - {p0[i][COORD_BITS-1], p0[i]};
            dneg[i] = -d[i];
            mag[i]  = d[i][COORD_BITS] ? dneg[i][COORD_BITS-1:0] : d[i][COORD_BITS-1:0];
        end
        span = (mag[0] > mag[1]) ? mag[0] : mag[1];
    end

    // restoring division step, increments and position update per lane
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            trial[i]    = {1'b0, rem_reg[i]} - {2'b00, span_reg};
            ge[i]       = !trial[i][STEP_BITS];
            rem[i]      = ge[i] ? trial[i][STEP_BITS-1:0] : rem_reg[i];
            qmag[i]     = {1'b0, q_reg[i]};
            inc[i]      = neg_reg[i] ? -qmag[i] : qmag[i];
            pos_next[i] = pos_reg[i] + {{EXT_BITS{inc[i][INC_BITS-1]}}, inc[i]};
            rnd_adv[i]  = pos_next[i] + HALF;
            rnd_cur[i]  = pos_reg[i] + HALF;
        end
    end

    // line state and dividers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.load)
            begin
                pos_reg[i] <= {p0[i], {FRAC_BITS{1'b0}}};
                rem_reg[i] <= {1'b0, mag[i]};
                q_reg[i]   <= '0;
                neg_reg[i] <= d[i][COORD_BITS];
            end
            else if (cmd.step)
            begin
                rem_reg[i] <= {rem[i][STEP_BITS-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i][Q_BITS-2:0], ge[i]};
            end
            else if (cmd.advance)
            begin
                pos_reg[i] <= pos_next[i];
            end
        end
        if (cmd.load)
        begin
            span_reg <= span;
        end
    end

    // pixels remaining on the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
        end
        else if (cmd.load)
        begin
            steps_reg <= {1'b0, span};
        end
        else if (cmd.advance)
        begin
            steps_reg <= steps_reg - STEP_BITS'(1);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            pix_x_reg <= rnd_adv[0][POS_BITS-1:FRAC_BITS];
            pix_y_reg <= rnd_adv[1][POS_BITS-1:FRAC_BITS];
            last_reg  <= (steps_reg == STEP_BITS'(1));
        end
        else if (cmd.emit)
        begin
            pix_x_reg <= rnd_cur[0][POS_BITS-1:FRAC_BITS];
            pix_y_reg <= rnd_cur[1][POS_BITS-1:FRAC_BITS];
            last_reg  <= (steps_reg == '0);
        end
    end

    assign status.zero_len = (span == '0);
    assign status.active   = (steps_reg != '0);

    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

endmodule

FILE: hw/rtl/dlpg_ctrl.sv
`timescale 1ns / 1ps

module dlpg_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   command,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  dlpg_pkg::dlpg_status_t status,
    output dlpg_pkg::dlpg_cmd_t    cmd
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic                out_free;
    logic                in_fire;

    assign out_free = !valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // sequencing of start and advance transactions
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == dlpg_pkg::CMD_START)
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = status.zero_len ? S_EMIT : S_DIV;
                    end
                    else if (status.active)
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(FRAC_BITS))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.advance || cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

endmodule

FILE: hw/rtl/dda_line_pixel_generator.sv
`timescale 1ns / 1ps

// DDA line pixel generator. A start transaction (command 0) takes the two
// endpoints, sets the step count to the larger of |dx| and |dy|, works out
// the per-axis increments as signed fixed point with FRAC_BITS fraction bits,
// and returns the start pixel; each advance transaction (command 1) adds the
// increments and returns the pixel rounded half up, with last_pixel marking
// the end of the line. An advance with no line in progress returns nothing,
// and a start always abandons the current line. An advance's pixel appears
// in the output register in the cycle after the advance is taken. A start
// occupies the block while the two bit-serial restoring dividers, which
// produce one quotient bit a cycle, work out the increments; a zero-length
// line skips the division. A new transaction is taken whenever the block is
// idle and the output register is empty or being read in the same cycle.
module dda_line_pixel_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last_pixel
);

    dlpg_pkg::dlpg_cmd_t    cmd;
    dlpg_pkg::dlpg_status_t status;

    // sequencer
    dlpg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // dividers, positions and output register
    dlpg_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

FILE: hw/rtl/dlpg_checker.sv
`timescale 1ns / 1ps

module dlpg_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  command,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  last_pixel
);

    // a start transaction always keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == dlpg_pkg::CMD_START |=> !in_ready)
        else $error("input taken right after a start transaction");

    // input is only taken when a waiting pixel leaves in the same cycle
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("input taken while the output register is full");

    // stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(last_pixel))
        else $error("output pixel changed while stalled");

    // pixel only disappears by a transaction
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output pixel dropped without a transaction");

endmodule

bind dda_line_pixel_generator dlpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlpg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
);

FILE: verif/dda_pixel_monitor.sv
`timescale 1ns / 1ps

module dda_pixel_monitor #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    input  logic                         last_pixel,
    output int                           fail_count,
    output int                           pending_count
);

    localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS  = FRAC_BITS + 2;
    localparam int STEP_BITS = COORD_BITS + 1;
    localparam logic [POS_BITS-1:0] ROUND_HALF = POS_BITS'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } pixel_t;

    // line walker state
    logic [POS_BITS-1:0]  x_pos;
    logic [POS_BITS-1:0]  y_pos;
    logic [INC_BITS-1:0]  x_inc;
    logic [INC_BITS-1:0]  y_inc;
    logic [STEP_BITS-1:0] steps_left;
    logic                 line_active;

    pixel_t expected_pixels[$];

    // per-axis increment: |d| / span truncated, then the sign of d applied
    function automatic logic [INC_BITS-1:0] scaled_increment(
        input logic [COORD_BITS:0] magnitude,
        input logic                negative,
        input logic [COORD_BITS:0] span
    );
        logic [COORD_BITS+FRAC_BITS:0] quotient;
        quotient = {magnitude, {FRAC_BITS{1'b0}}} / span;
        if (negative)
            quotient = -quotient;
        return quotient[INC_BITS-1:0];
    endfunction

    // advance the walker by one transaction and queue the pixel it yields
    task automatic walk_line(
        input logic                         cmd,
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy,
        input logic signed [COORD_BITS-1:0] ex,
        input logic signed [COORD_BITS-1:0] ey
    );
        logic signed [COORD_BITS:0] dx;
        logic signed [COORD_BITS:0] dy;
        logic [COORD_BITS:0]        ax;
        logic [COORD_BITS:0]        ay;
        logic [COORD_BITS:0]        span;
        logic [POS_BITS-1:0]        rx;
        logic [POS_BITS-1:0]        ry;
        pixel_t                     px;
        if (cmd == dlpg_pkg::CMD_START)
        begin
            dx = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
            dy = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
            ax = dx[COORD_BITS] ? -dx : dx;
            ay = dy[COORD_BITS] ? -dy : dy;
            span = (ax > ay) ? ax : ay;
            x_pos = {sx, {FRAC_BITS{1'b0}}};
            y_pos = {sy, {FRAC_BITS{1'b0}}};
            px.x = sx;
            px.y = sy;
            if (span == 0)
            begin
                // zero-length line: single pixel, stays idle
                x_inc = '0;
                y_inc = '0;
                steps_left = '0;
                line_active = 1'b0;
                px.last = 1'b1;
            end
            else
            begin
                x_inc = scaled_increment(ax, dx[COORD_BITS], span);
                y_inc = scaled_increment(ay, dy[COORD_BITS], span);
                steps_left = span;
                line_active = 1'b1;
                px.last = 1'b0;
            end
            expected_pixels.push_back(px);
        end
        else if (!line_active || steps_left == 0)
        begin
            // advance with no line in progress yields nothing
            line_active = 1'b0;
        end
        else
        begin
            x_pos = x_pos + {{(POS_BITS-INC_BITS){x_inc[INC_BITS-1]}}, x_inc};
            y_pos = y_pos + {{(POS_BITS-INC_BITS){y_inc[INC_BITS-1]}}, y_inc};
            steps_left = steps_left - 1'b1;
            // round half up, wrapping in the position width
            rx = x_pos + ROUND_HALF;
            ry = y_pos + ROUND_HALF;
            px.x = rx[POS_BITS-1:FRAC_BITS];
            px.y = ry[POS_BITS-1:FRAC_BITS];
            px.last = (steps_left == 0);
            if (steps_left == 0)
                line_active = 1'b0;
            expected_pixels.push_back(px);
        end
    endtask

    // compare result transactions, then predict from input transactions
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            x_pos = '0;
            y_pos = '0;
            x_inc = '0;
            y_inc = '0;
            steps_left = '0;
            line_active = 1'b0;
            expected_pixels.delete();
            pending_count = 0;
        end
        else
        begin
            // results first, so a pixel predicted at this edge is not matched yet
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected pixel, expected none, got x=%0d y=%0d last=%0d",
                             $time, pixel_x, pixel_y, last_pixel);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.x !== pixel_x || want.y !== pixel_y
                        || want.last !== last_pixel)
                    begin
                        $display({"%0t ns: pixel mismatch, expected x=%0d y=%0d last=%0d,",
                                  " got x=%0d y=%0d last=%0d"},
                                 $time, want.x, want.y, want.last,
                                 pixel_x, pixel_y, last_pixel);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                walk_line(command, start_x, start_y, end_x, end_y);
            pending_count = expected_pixels.size();
        end
    end

endmodule

FILE: verif/tb_dda_line_pixel_generator.sv
`timescale 1ns / 1ps

module tb_dda_line_pixel_generator;

    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 16;
    localparam int CLK_PERIOD     = 8;
    localparam int LINE_ITEMS     = 650;
    localparam int DRAIN_CYCLES   = 2 * (FRAC_BITS + 3);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKED
    } rx_mode_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         command = dlpg_pkg::CMD_ADVANCE;
    logic signed [COORD_BITS-1:0] start_x = '0;
    logic signed [COORD_BITS-1:0] start_y = '0;
    logic signed [COORD_BITS-1:0] end_x = '0;
    logic signed [COORD_BITS-1:0] end_y = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    int fail_count;
    int pending_count;
    int quiet_cycles;
    int burst_left;
    int line_items;
    int walk_left;

    rx_mode_t rx_mode = RX_STREAM;
    int       rx_mode_left;
    int       rx_phase;

    always #(CLK_PERIOD / 2) clk = ~clk;

    dda_line_pixel_generator #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last_pixel(last_pixel)
    );

    dda_pixel_monitor #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pixel_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_pixel   (last_pixel),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // receiver stall pattern, redrawn when the current one runs out
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = int'($urandom_range(16, 200));
            rx_phase = 0;
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            RX_STREAM: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ((rx_phase % 16) >= 12);
        endcase
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic logic [COORD_BITS-1:0] to_coord(input int v);
        return COORD_BITS'(v);
    endfunction

    // one input transaction, sent in bursts with random gaps between them
    task automatic send_transaction(
        input logic                  cmd,
        input logic [COORD_BITS-1:0] sx,
        input logic [COORD_BITS-1:0] sy,
        input logic [COORD_BITS-1:0] ex,
        input logic [COORD_BITS-1:0] ey
    );
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 24));
            // about a third of the bursts follow with no gap
            if ($urandom_range(0, 2) != 0)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic start_line(
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy,
        input logic signed [COORD_BITS-1:0] ex,
        input logic signed [COORD_BITS-1:0] ey
    );
        int dx;
        int dy;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        walk_left = (dx > dy) ? dx : dy;
        line_items++;
        send_transaction(dlpg_pkg::CMD_START, sx, sy, ex, ey);
    endtask

    // advances carry random, ignored endpoint fields
    task automatic advance_line(input int count);
        repeat (count)
        begin
            if (walk_left > 0)
            begin
                line_items++;
                walk_left--;
            end
            send_transaction(dlpg_pkg::CMD_ADVANCE, rand_coord(), rand_coord(),
                             rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        int                    shape;
        int                    walk;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // advance straight out of reset: idle, no pixel
        advance_line(1);
        // zero-length lines, at the origin and at the coordinate extremes
        start_line(to_coord(0), to_coord(0), to_coord(0), to_coord(0));
        start_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        // full diagonal, abandoned after two pixels by a new start
        start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        advance_line(2);
        start_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        advance_line(1);
        // short line walked to the end, plus one advance past it
        start_line(to_coord(0), to_coord(0), to_coord(3), to_coord(-2));
        advance_line(4);
        // vertical line going down
        start_line(to_coord(5), to_coord(5), to_coord(5), to_coord(1));
        advance_line(4);
        // negative coordinates where floor differs from truncation
        start_line(to_coord(-1), to_coord(-1), to_coord(-2), to_coord(-3));
        advance_line(2);

        // random lines, mostly short and walked to the end
        while (line_items < LINE_ITEMS)
        begin
            sx = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? COORD_MIN
                                                                             : COORD_MAX)
                                             : rand_coord();
            sy = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? COORD_MIN
                                                                             : COORD_MAX)
                                             : rand_coord();
            shape = int'($urandom_range(0, 9));
            if (shape < 6)
            begin
                ex = COORD_BITS'(sx + $urandom_range(0, 24) - 12);
                ey = COORD_BITS'(sy + $urandom_range(0, 24) - 12);
            end
            else if (shape < 8)
            begin
                ex = COORD_BITS'(sx + $urandom_range(0, 400) - 200);
                ey = COORD_BITS'(sy + $urandom_range(0, 400) - 200);
            end
            else if (shape == 8)
            begin
                ex = rand_coord();
                ey = rand_coord();
            end
            else
            begin
                ex = sx;
                ey = ($urandom_range(0, 1) != 0) ? sy
                                                 : COORD_BITS'(sy + $urandom_range(0, 8) - 4);
            end
            start_line(sx, sy, ex, ey);
            if (walk_left <= 64 && $urandom_range(0, 4) != 0)
                walk = walk_left + int'($urandom_range(0, 5) == 0);
            else
                walk = int'($urandom_range(0, (walk_left < 20) ? walk_left : 20));
            advance_line(walk);
            // stray advance, either mid-line or with nothing in progress
            if ($urandom_range(0, 7) == 0)
                advance_line(1);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
